@@ hdl/residue_side_angle_histogram_assert.svh @@
// ----------------------------------------------------------------------------
// Residue side angle histogram assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RESIDUE_SIDE_ANGLE_HISTOGRAM_ASSERT_SVH
`define RESIDUE_SIDE_ANGLE_HISTOGRAM_ASSERT_SVH

`ifndef SYNTHESIS
`define RSAH_ASSERT_HOLDS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rsah assertion failed");
`define RSAH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rsah assertion failed");
`else
`define RSAH_ASSERT_HOLDS(lbl, pre, post)
`define RSAH_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ hdl/rsah_pkg.sv @@
// ----------------------------------------------------------------------------
// Residue side angle histogram package
// Shared widths, constants, command codes, handshake structs and tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsah_pkg;

  localparam int NUM_BINS      = 37;
  localparam int BIN_WIDTH_DEG = 5;
  localparam int COORD_BITS    = 24;
  localparam int COUNT_BITS    = 32;

  localparam int BIN_BITS = $clog2(NUM_BINS);
  localparam int IN_W     = 25;
  localparam int U_W      = IN_W + 2;
  localparam int MAG_W    = U_W - 1;
  localparam int SC_BITS  = 15;
  localparam int SC_W     = SC_BITS + 1;
  localparam int CR_W     = 33;
  localparam int DOT_W    = 34;
  localparam int SQ_W     = 64;
  localparam int RX_W     = 36;
  localparam int Z_W      = 26;
  localparam int ZC_W     = 24;
  localparam int TEN_W    = 11;
  localparam int CMP_W    = 34;

  localparam int ANG_ONE      = 65536;
  localparam int CORDIC_STEPS = 23;
  localparam int STEP_BITS    = 5;
  localparam int ZMAX         = 180 * ANG_ONE;
  localparam int Z_QUARTER    = 90 * ANG_ONE;
  localparam int HALF_BIN     = BIN_WIDTH_DEG * ANG_ONE;
  localparam int RECIP_SH     = 16;
  localparam int BIN_RECIP    = ((1 << RECIP_SH) + BIN_WIDTH_DEG - 1) / BIN_WIDTH_DEG;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_RESIDUE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                   start;
    logic [2:0][U_W-1:0]    u;
    logic [2:0][U_W-1:0]    v;
  } angle_req_t;

  typedef struct packed {
    logic                   done;
    logic [TEN_W-1:0]       tenths;
    logic [BIN_BITS-1:0]    bin;
  } angle_rsp_t;

  function automatic logic signed [IN_W-1:0] sat_coord(input logic signed [IN_W-1:0] c);
    logic signed [CMP_W-1:0] ext;
    logic signed [CMP_W-1:0] lim;
    logic signed [IN_W-1:0]  res;
    ext = CMP_W'(c);
    lim = CMP_W'((64'd1 << COORD_BITS) - 64'd1);
    if (ext > lim) begin
      res = lim[IN_W-1:0];
    end else if (ext < -lim) begin
      res = IN_W'(-lim);
    end else begin
      res = c;
    end
    return res;
  endfunction

  function automatic logic [21:0] atan_entry(input logic [STEP_BITS-1:0] i);
    logic [21:0] a;
    case (i)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      5'd20: a = 22'd4;
      5'd21: a = 22'd2;
      5'd22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/rsah_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 37
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/rsah_angle.sv @@
// ----------------------------------------------------------------------------
// Residue side angle engine
// Scales both vectors, forms cross and dot products on one shared multiplier,
// takes an integer square root bit pair by bit pair, rotates CORDIC and bins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsah_angle (
  input  logic                clk,
  input  logic                rst,
  input  rsah_pkg::angle_req_t req,
  output rsah_pkg::angle_rsp_t rsp
);

  typedef enum logic [2:0] {
    E_IDLE, E_SCALE, E_MUL, E_ACC, E_SQRT, E_CINIT, E_ROT, E_FIN
  } estate_t;

  typedef enum logic [3:0] {
    OP_CX_A, OP_CX_B, OP_CY_A, OP_CY_B, OP_CZ_A, OP_CZ_B,
    OP_D_0, OP_D_1, OP_D_2, OP_SQ_X, OP_SQ_Y, OP_SQ_Z
  } op_t;

  estate_t state;
  op_t     op;

  logic [rsah_pkg::MAG_W-1:0] umag [3];
  logic [rsah_pkg::MAG_W-1:0] vmag [3];
  logic [2:0]                 usgn;
  logic [2:0]                 vsgn;

  logic signed [rsah_pkg::CR_W-1:0]  uext [3];
  logic signed [rsah_pkg::CR_W-1:0]  vext [3];
  logic signed [rsah_pkg::CR_W-1:0]  opa;
  logic signed [rsah_pkg::CR_W-1:0]  opb;
  logic signed [2*rsah_pkg::CR_W-1:0] full;
  logic signed [rsah_pkg::SQ_W-1:0]  prod;

  logic signed [rsah_pkg::CR_W-1:0]  cx;
  logic signed [rsah_pkg::CR_W-1:0]  cy;
  logic signed [rsah_pkg::CR_W-1:0]  cz;
  logic signed [rsah_pkg::DOT_W-1:0] dot;
  logic [rsah_pkg::SQ_W-1:0]         sq;

  logic [rsah_pkg::SQ_W-1:0] sn;
  logic [rsah_pkg::SQ_W-1:0] sr;
  logic [rsah_pkg::SQ_W-1:0] sbit;
  logic [rsah_pkg::SQ_W-1:0] strial;

  logic signed [rsah_pkg::RX_W-1:0] rx;
  logic signed [rsah_pkg::RX_W-1:0] ry;
  logic signed [rsah_pkg::Z_W-1:0]  rz;
  logic [rsah_pkg::STEP_BITS-1:0]   step;
  logic signed [rsah_pkg::RX_W-1:0] dx;
  logic signed [rsah_pkg::RX_W-1:0] dy;
  logic signed [rsah_pkg::Z_W-1:0]  datan;
  logic signed [rsah_pkg::RX_W-1:0] dot_ext;

  logic       u_zero;
  logic       v_zero;
  logic       u_big;
  logic       v_big;

  logic [rsah_pkg::ZC_W-1:0]   zc;
  logic [rsah_pkg::ZC_W+3:0]   tsum;
  logic [rsah_pkg::ZC_W+1:0]   nsum;
  logic [8:0]                  mq;
  logic [24:0]                 qprod;
  logic [8:0]                  q;
  logic [rsah_pkg::BIN_BITS-1:0] bin;

  always_comb begin
    u_zero = 1'b1;
    v_zero = 1'b1;
    u_big  = 1'b0;
    v_big  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (req.u[k] != '0) u_zero = 1'b0;
      if (req.v[k] != '0) v_zero = 1'b0;
      if (umag[k][rsah_pkg::MAG_W-1:rsah_pkg::SC_BITS] != '0) u_big = 1'b1;
      if (vmag[k][rsah_pkg::MAG_W-1:rsah_pkg::SC_BITS] != '0) v_big = 1'b1;
      uext[k] = usgn[k] ? -rsah_pkg::CR_W'(umag[k][rsah_pkg::SC_BITS-1:0])
                        :  rsah_pkg::CR_W'(umag[k][rsah_pkg::SC_BITS-1:0]);
      vext[k] = vsgn[k] ? -rsah_pkg::CR_W'(vmag[k][rsah_pkg::SC_BITS-1:0])
                        :  rsah_pkg::CR_W'(vmag[k][rsah_pkg::SC_BITS-1:0]);
    end
  end

  always_comb begin
    case (op)
      OP_CX_A: begin opa = uext[1]; opb = vext[2]; end
      OP_CX_B: begin opa = uext[2]; opb = vext[1]; end
      OP_CY_A: begin opa = uext[2]; opb = vext[0]; end
      OP_CY_B: begin opa = uext[0]; opb = vext[2]; end
      OP_CZ_A: begin opa = uext[0]; opb = vext[1]; end
      OP_CZ_B: begin opa = uext[1]; opb = vext[0]; end
      OP_D_0:  begin opa = uext[0]; opb = vext[0]; end
      OP_D_1:  begin opa = uext[1]; opb = vext[1]; end
      OP_D_2:  begin opa = uext[2]; opb = vext[2]; end
      OP_SQ_X: begin opa = cx;      opb = cx;      end
      OP_SQ_Y: begin opa = cy;      opb = cy;      end
      OP_SQ_Z: begin opa = cz;      opb = cz;      end
      default: begin opa = '0;      opb = '0;      end
    endcase
  end

  assign full    = opa * opb;
  assign strial  = sr + sbit;
  assign dx      = ry >>> step;
  assign dy      = rx >>> step;
  assign datan   = rsah_pkg::Z_W'(rsah_pkg::atan_entry(step));
  assign dot_ext = rsah_pkg::RX_W'(dot);

  always_comb begin
    if (rz[rsah_pkg::Z_W-1]) begin
      zc = '0;
    end else if (rz > rsah_pkg::Z_W'(rsah_pkg::ZMAX)) begin
      zc = rsah_pkg::ZC_W'(rsah_pkg::ZMAX);
    end else begin
      zc = rz[rsah_pkg::ZC_W-1:0];
    end
    tsum  = {zc, 3'b000} + {2'b00, zc, 1'b0} + (rsah_pkg::ZC_W+4)'(rsah_pkg::ANG_ONE / 2);
    nsum  = {1'b0, zc, 1'b0} + (rsah_pkg::ZC_W+2)'(rsah_pkg::HALF_BIN);
    mq    = nsum[rsah_pkg::ZC_W+1:17];
    qprod = 25'(mq) * 25'(rsah_pkg::BIN_RECIP);
    q     = qprod[24:rsah_pkg::RECIP_SH];
    if (q > 9'(rsah_pkg::NUM_BINS - 1)) begin
      bin = rsah_pkg::BIN_BITS'(rsah_pkg::NUM_BINS - 1);
    end else begin
      bin = q[rsah_pkg::BIN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      op       <= OP_CX_A;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        E_IDLE: begin
          if (req.start) begin
            for (int k = 0; k < 3; k++) begin
              usgn[k] <= req.u[k][rsah_pkg::U_W-1];
              vsgn[k] <= req.v[k][rsah_pkg::U_W-1];
              umag[k] <= req.u[k][rsah_pkg::U_W-1] ? rsah_pkg::MAG_W'(-$signed(req.u[k]))
                                                   : req.u[k][rsah_pkg::MAG_W-1:0];
              vmag[k] <= req.v[k][rsah_pkg::U_W-1] ? rsah_pkg::MAG_W'(-$signed(req.v[k]))
                                                   : req.v[k][rsah_pkg::MAG_W-1:0];
            end
            op <= OP_CX_A;
            if (u_zero || v_zero) begin
              rz    <= '0;
              state <= E_FIN;
            end else begin
              state <= E_SCALE;
            end
          end
        end
        E_SCALE: begin
          for (int k = 0; k < 3; k++) begin
            if (u_big) umag[k] <= umag[k] >> 1;
            if (v_big) vmag[k] <= vmag[k] >> 1;
          end
          if (!u_big && !v_big) state <= E_MUL;
        end
        E_MUL: begin
          prod  <= full[rsah_pkg::SQ_W-1:0];
          state <= E_ACC;
        end
        E_ACC: begin
          state <= E_MUL;
          op    <= op_t'(op + 4'd1);
          case (op)
            OP_CX_A: cx  <= prod[rsah_pkg::CR_W-1:0];
            OP_CX_B: cx  <= cx - prod[rsah_pkg::CR_W-1:0];
            OP_CY_A: cy  <= prod[rsah_pkg::CR_W-1:0];
            OP_CY_B: cy  <= cy - prod[rsah_pkg::CR_W-1:0];
            OP_CZ_A: cz  <= prod[rsah_pkg::CR_W-1:0];
            OP_CZ_B: cz  <= cz - prod[rsah_pkg::CR_W-1:0];
            OP_D_0:  dot <= prod[rsah_pkg::DOT_W-1:0];
            OP_D_1:  dot <= dot + prod[rsah_pkg::DOT_W-1:0];
            OP_D_2:  dot <= dot + prod[rsah_pkg::DOT_W-1:0];
            OP_SQ_X: sq  <= prod;
            OP_SQ_Y: sq  <= sq + prod;
            OP_SQ_Z: begin
              sn    <= sq + prod;
              sr    <= '0;
              sbit  <= rsah_pkg::SQ_W'(1) << (rsah_pkg::SQ_W - 2);
              state <= E_SQRT;
            end
            default: state <= E_IDLE;
          endcase
        end
        E_SQRT: begin
          if (sn >= strial) begin
            sn <= sn - strial;
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) state <= E_CINIT;
        end
        E_CINIT: begin
          step <= '0;
          if (dot[rsah_pkg::DOT_W-1]) begin
            rx <= $signed(sr[rsah_pkg::RX_W-1:0]);
            ry <= -dot_ext;
            rz <= rsah_pkg::Z_W'(rsah_pkg::Z_QUARTER);
          end else begin
            rx <= dot_ext;
            ry <= $signed(sr[rsah_pkg::RX_W-1:0]);
            rz <= '0;
          end
          state <= E_ROT;
        end
        E_ROT: begin
          if (ry > 0) begin
            rx <= rx + dx;
            ry <= ry - dy;
            rz <= rz + datan;
          end else begin
            rx <= rx - dx;
            ry <= ry + dy;
            rz <= rz - datan;
          end
          step <= step + 1'b1;
          if (step == rsah_pkg::STEP_BITS'(rsah_pkg::CORDIC_STEPS - 1)) state <= E_FIN;
        end
        E_FIN: begin
          rsp.done   <= 1'b1;
          rsp.tenths <= tsum[rsah_pkg::ZC_W+2:16];
          rsp.bin    <= bin;
          state      <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/residue_side_angle_histogram.sv @@
// ----------------------------------------------------------------------------
// Residue side angle histogram
// Per-residue side-chain angle from a three-residue alpha window, binned.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command per transaction:
// a residue, a read of one histogram bin, a clear, or a no-op.
// Output channel (out_valid / out_stall) returns exactly one result per
// command: angle fields, the requested bin count and the highest bin so far.
// The block takes one command at a time; in_stall is high until its result
// has been loaded into the output register.
// A residue that yields an angle passes through start, scaling, 12 products on
// the shared multiplier (each a multiply and an accumulate state), 32
// square-root steps, 1 CORDIC set-up and 23 rotations, then the histogram
// read-modify-write and output load. A residue with a zero vector skips the
// arithmetic; an in-range bin read adds only the RAM read, and any other
// command goes straight to the output load.
// A stalled result holds in the output register; the next command is taken
// meanwhile and its result waits until the register frees.
// Reset clears the window, top bin and all bin counts (through per-bin valid
// flags) at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "residue_side_angle_histogram_assert.svh"

module residue_side_angle_histogram (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           cmd,
  input  logic                                 chain_start,
  input  logic signed [rsah_pkg::IN_W-1:0]     alpha_x,
  input  logic signed [rsah_pkg::IN_W-1:0]     alpha_y,
  input  logic signed [rsah_pkg::IN_W-1:0]     alpha_z,
  input  logic signed [rsah_pkg::IN_W-1:0]     beta_x,
  input  logic signed [rsah_pkg::IN_W-1:0]     beta_y,
  input  logic signed [rsah_pkg::IN_W-1:0]     beta_z,
  input  logic                                 beta_present,
  input  logic [5:0]                           read_bin,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 angle_valid,
  output logic [rsah_pkg::TEN_W-1:0]           angle_tenths,
  output logic [5:0]                           angle_bin,
  output logic [rsah_pkg::COUNT_BITS-1:0]      bin_count,
  output logic [5:0]                           highest_bin
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ANGLE, ST_RD, ST_WR, ST_PUT
  } state_t;

  state_t state;

  logic signed [rsah_pkg::IN_W-1:0] alpha0 [3];
  logic signed [rsah_pkg::IN_W-1:0] alpha1 [3];
  logic signed [rsah_pkg::IN_W-1:0] mbeta  [3];
  logic                             mbeta_present;
  logic [1:0]                       residues;
  logic [rsah_pkg::BIN_BITS-1:0]    top_bin;
  logic [rsah_pkg::NUM_BINS-1:0]    entry_valid;

  logic signed [rsah_pkg::IN_W-1:0] a_sat [3];
  logic signed [rsah_pkg::IN_W-1:0] b_sat [3];
  logic signed [rsah_pkg::U_W-1:0]  u_calc [3];
  logic signed [rsah_pkg::U_W-1:0]  v_calc [3];
  logic [1:0]                       win_start;
  logic                             do_angle;
  logic                             in_take;
  logic                             out_free;

  rsah_pkg::angle_req_t req;
  rsah_pkg::angle_rsp_t rsp;

  logic                            is_residue;
  logic [rsah_pkg::BIN_BITS-1:0]   rd_addr;
  logic                            rd_ok;
  logic [rsah_pkg::COUNT_BITS-1:0] rdata;
  logic [rsah_pkg::COUNT_BITS-1:0] cur_count;
  logic                            ram_we;
  logic [rsah_pkg::COUNT_BITS-1:0] ram_wdata;

  logic                            res_valid;
  logic [rsah_pkg::TEN_W-1:0]      res_tenths;
  logic [rsah_pkg::BIN_BITS-1:0]   res_bin;
  logic [rsah_pkg::COUNT_BITS-1:0] res_count;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    a_sat[0] = rsah_pkg::sat_coord(alpha_x);
    a_sat[1] = rsah_pkg::sat_coord(alpha_y);
    a_sat[2] = rsah_pkg::sat_coord(alpha_z);
    b_sat[0] = rsah_pkg::sat_coord(beta_x);
    b_sat[1] = rsah_pkg::sat_coord(beta_y);
    b_sat[2] = rsah_pkg::sat_coord(beta_z);
    for (int k = 0; k < 3; k++) begin
      u_calc[k] = $signed({alpha1[k][rsah_pkg::IN_W-1], alpha1[k], 1'b0})
                - rsah_pkg::U_W'(alpha0[k]) - rsah_pkg::U_W'(a_sat[k]);
      v_calc[k] = rsah_pkg::U_W'(mbeta[k]) - rsah_pkg::U_W'(alpha1[k]);
    end
    win_start = chain_start ? 2'd0 : residues;
    do_angle  = (win_start == 2'd2) && mbeta_present;
  end

  assign cur_count = rd_ok ? rdata : '0;
  assign ram_we    = (state == ST_WR) && is_residue;
  assign ram_wdata = (cur_count == rsah_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;

  rsah_ram #(
    .WIDTH (rsah_pkg::COUNT_BITS),
    .DEPTH (rsah_pkg::NUM_BINS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  rsah_angle u_angle (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      req.start     <= 1'b0;
      mbeta_present <= 1'b0;
      residues      <= 2'd0;
      top_bin       <= '0;
      entry_valid   <= '0;
      for (int k = 0; k < 3; k++) begin
        alpha0[k] <= '0;
        alpha1[k] <= '0;
        mbeta[k]  <= '0;
      end
    end else begin
      req.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            res_valid  <= 1'b0;
            res_tenths <= '0;
            res_bin    <= '0;
            res_count  <= '0;
            is_residue <= 1'b0;
            state      <= ST_PUT;
            case (rsah_pkg::cmd_t'(cmd))
              rsah_pkg::CMD_RESIDUE: begin
                for (int k = 0; k < 3; k++) begin
                  req.u[k]  <= u_calc[k];
                  req.v[k]  <= v_calc[k];
                  alpha0[k] <= alpha1[k];
                  alpha1[k] <= a_sat[k];
                  mbeta[k]  <= b_sat[k];
                end
                mbeta_present <= beta_present;
                residues      <= (win_start == 2'd2) ? 2'd2 : win_start + 2'd1;
                if (do_angle) begin
                  req.start  <= 1'b1;
                  is_residue <= 1'b1;
                  state      <= ST_ANGLE;
                end
              end
              rsah_pkg::CMD_READ: begin
                if (read_bin < 6'(rsah_pkg::NUM_BINS)) begin
                  rd_addr <= read_bin[rsah_pkg::BIN_BITS-1:0];
                  state   <= ST_RD;
                end
              end
              rsah_pkg::CMD_CLEAR: begin
                entry_valid   <= '0;
                top_bin       <= '0;
                residues      <= 2'd0;
                mbeta_present <= 1'b0;
              end
              default: state <= ST_PUT;
            endcase
          end
        end
        ST_ANGLE: begin
          if (rsp.done) begin
            res_valid  <= 1'b1;
            res_tenths <= rsp.tenths;
            res_bin    <= rsp.bin;
            rd_addr    <= rsp.bin;
            state      <= ST_RD;
          end
        end
        ST_RD: begin
          rd_ok <= entry_valid[rd_addr];
          state <= ST_WR;
        end
        ST_WR: begin
          if (is_residue) begin
            entry_valid[rd_addr] <= 1'b1;
            if (rd_addr > top_bin) top_bin <= rd_addr;
          end else begin
            res_count <= cur_count;
          end
          state <= ST_PUT;
        end
        ST_PUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            angle_valid  <= res_valid;
            angle_tenths <= res_tenths;
            angle_bin    <= 6'(res_bin);
            bin_count    <= res_count;
            highest_bin  <= 6'(top_bin);
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RSAH_ASSERT_HOLDS(a_resp_in_angle, rsp.done, state == ST_ANGLE)
  `RSAH_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `RSAH_ASSERT_HOLDS(a_bin_le_top, out_valid && angle_valid, angle_bin <= highest_bin)
  `RSAH_ASSERT_HOLDS(a_no_angle_zero, out_valid && !angle_valid, angle_tenths == '0 && angle_bin == '0)

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Residue side angle histogram testbench
// Sends residues, bin reads, clears and no-ops with random gaps and output
// stalls. A scoreboard predicts every result and compares each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef struct {
    rsah_pkg::cmd_t op;
    bit             chain_start;
    logic [24:0]    ax, ay, az, bx, by, bz;
    bit             beta_present;
    logic [5:0]     read_bin;
  } command_t;

  typedef struct packed {
    bit          angle_valid;
    logic [10:0] angle_tenths;
    logic [5:0]  angle_bin;
    logic [31:0] bin_count;
    logic [5:0]  highest_bin;
  } result_t;

  class angle_scoreboard;
    longint  win_alpha[2][3];
    longint  mid_beta[3];
    bit      mid_beta_known;
    int      window_fill;
    longint  counts[rsah_pkg::NUM_BINS];
    int      top;
    result_t expected_results[$];
    int      mismatches;

    function new();
      foreach (win_alpha[i, k]) win_alpha[i][k] = 0;
      foreach (mid_beta[k]) mid_beta[k] = 0;
      mid_beta_known = 0;
      window_fill = 0;
      foreach (counts[i]) counts[i] = 0;
      top = 0;
      mismatches = 0;
    endfunction

    function longint clamp_coord(logic [24:0] raw);
      longint v;
      longint lim;
      v = longint'(signed'(raw));
      lim = (longint'(1) << rsah_pkg::COORD_BITS) - 1;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
    endfunction

    function void shrink(input longint a[3], output longint o[3]);
      longint m;
      longint mag;
      int s;
      m = 0;
      s = 0;
      for (int k = 0; k < 3; k++) begin
        mag = a[k] < 0 ? -a[k] : a[k];
        if (mag > m) m = mag;
      end
      while ((m >> s) >= 32768) s++;
      for (int k = 0; k < 3; k++) begin
        mag = a[k] < 0 ? -a[k] : a[k];
        mag = mag >> s;
        o[k] = a[k] < 0 ? -mag : mag;
      end
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] n);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint side_angle(input longint u0[3], input longint v0[3]);
      longint u[3], v[3];
      longint cx, cy, cz, d, x, y, z, dx, dy, t;
      bit [63:0] sq;
      if ((u0[0] | u0[1] | u0[2]) == 0 || (v0[0] | v0[1] | v0[2]) == 0) return 0;
      shrink(u0, u);
      shrink(v0, v);
      cx = u[1] * v[2] - u[2] * v[1];
      cy = u[2] * v[0] - u[0] * v[2];
      cz = u[0] * v[1] - u[1] * v[0];
      sq = 64'(cx * cx) + 64'(cy * cy) + 64'(cz * cz);
      d = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      x = d;
      y = longint'(int_sqrt(sq));
      z = 0;
      if (x < 0) begin
        t = x;
        x = y;
        y = -t;
        z = rsah_pkg::Z_QUARTER;
      end
      for (int i = 0; i < rsah_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += longint'(rsah_pkg::atan_entry(rsah_pkg::STEP_BITS'(i)));
        end else begin
          x -= dx;
          y += dy;
          z -= longint'(rsah_pkg::atan_entry(rsah_pkg::STEP_BITS'(i)));
        end
      end
      if (z < 0) z = 0;
      if (z > rsah_pkg::ZMAX) z = rsah_pkg::ZMAX;
      return z;
    endfunction

    function void note_command(command_t c);
      result_t r;
      longint a[3], b[3], u[3], v[3], z, bn;
      r = '{0, 0, 0, 0, 0};
      case (c.op)
        rsah_pkg::CMD_RESIDUE: begin
          a[0] = clamp_coord(c.ax); a[1] = clamp_coord(c.ay); a[2] = clamp_coord(c.az);
          b[0] = clamp_coord(c.bx); b[1] = clamp_coord(c.by); b[2] = clamp_coord(c.bz);
          if (c.chain_start) window_fill = 0;
          if (window_fill >= 2 && mid_beta_known) begin
            for (int k = 0; k < 3; k++) begin
              u[k] = 2 * win_alpha[1][k] - win_alpha[0][k] - a[k];
              v[k] = mid_beta[k] - win_alpha[1][k];
            end
            z = side_angle(u, v);
            bn = (2 * z + rsah_pkg::BIN_WIDTH_DEG * rsah_pkg::ANG_ONE) /
                 (2 * rsah_pkg::BIN_WIDTH_DEG * rsah_pkg::ANG_ONE);
            if (bn > rsah_pkg::NUM_BINS - 1) bn = rsah_pkg::NUM_BINS - 1;
            if (counts[bn] < longint'(rsah_pkg::COUNT_MAX)) counts[bn]++;
            if (bn > top) top = int'(bn);
            r.angle_valid = 1;
            r.angle_tenths = 11'((z * 10 + rsah_pkg::ANG_ONE / 2) / rsah_pkg::ANG_ONE);
            r.angle_bin = 6'(bn);
          end
          for (int k = 0; k < 3; k++) begin
            win_alpha[0][k] = win_alpha[1][k];
            win_alpha[1][k] = a[k];
            mid_beta[k] = b[k];
          end
          mid_beta_known = c.beta_present;
          if (window_fill < 2) window_fill++;
        end
        rsah_pkg::CMD_READ:
          r.bin_count = c.read_bin < rsah_pkg::NUM_BINS ? 32'(counts[c.read_bin]) : 0;
        rsah_pkg::CMD_CLEAR: begin
          foreach (counts[i]) counts[i] = 0;
          top = 0;
          window_fill = 0;
          mid_beta_known = 0;
        end
        default: ;
      endcase
      r.highest_bin = 6'(top);
      expected_results = {expected_results, r};
    endfunction

    function bit check_result(result_t got);
      result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
        return 0;
      end
      e = expected_results.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at %0t: expected v%0d t%0d b%0d c%0d h%0d,",
                    " got v%0d t%0d b%0d c%0d h%0d"},
                   $realtime, e.angle_valid, e.angle_tenths, e.angle_bin, e.bin_count,
                   e.highest_bin, got.angle_valid, got.angle_tenths, got.angle_bin,
                   got.bin_count, got.highest_bin);
      end
      return 1;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  cmd = rsah_pkg::CMD_NOP;
  logic        chain_start = 0;
  logic signed [rsah_pkg::IN_W-1:0] alpha_x = 0, alpha_y = 0, alpha_z = 0;
  logic signed [rsah_pkg::IN_W-1:0] beta_x = 0, beta_y = 0, beta_z = 0;
  logic        beta_present = 0;
  logic [5:0]  read_bin = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        angle_valid;
  logic [rsah_pkg::TEN_W-1:0] angle_tenths;
  logic [5:0]  angle_bin;
  logic [rsah_pkg::COUNT_BITS-1:0] bin_count;
  logic [5:0]  highest_bin;

  angle_scoreboard sb = new();
  bit     quiet = 0;
  int     stall_left = 0;
  int     idle_cycles = 0;
  longint chain_pos[3] = '{0, 0, 0};

  residue_side_angle_histogram uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
    if (!rst && out_valid && !out_stall) begin
      void'(sb.check_result('{angle_valid, angle_tenths, angle_bin, bin_count, highest_bin}));
      stall_left = quiet ? 0 : $urandom_range(0, 16);
    end
    if (stall_left > 0) begin
      out_stall <= 1;
      stall_left--;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(command_t c);
    int gap;
    in_valid <= 1;
    cmd <= c.op;
    chain_start <= c.chain_start;
    alpha_x <= c.ax; alpha_y <= c.ay; alpha_z <= c.az;
    beta_x <= c.bx; beta_y <= c.by; beta_z <= c.bz;
    beta_present <= c.beta_present;
    read_bin <= c.read_bin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(c);
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic command_t plain(rsah_pkg::cmd_t op);
    command_t c;
    c = '{op, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    c.read_bin = 6'($urandom);
    return c;
  endfunction

  function automatic command_t residue(bit cs, longint ax, longint ay, longint az,
                                       longint bx, longint by, longint bz, bit bp);
    return '{rsah_pkg::CMD_RESIDUE, cs, 25'(ax), 25'(ay), 25'(az), 25'(bx), 25'(by),
             25'(bz), bp, 6'($urandom)};
  endfunction

  function automatic longint wander(longint p, int step);
    longint n;
    n = p + $urandom_range(0, 2 * step) - step;
    if (n > 9999999 || n < -9999999) n = 0;
    return n;
  endfunction

  function automatic command_t random_command();
    command_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return plain(rsah_pkg::CMD_READ);
    if (pick < 14) return plain(rsah_pkg::CMD_CLEAR);
    if (pick < 16) return plain(rsah_pkg::CMD_NOP);
    if (pick < 28) begin
      c = plain(rsah_pkg::CMD_RESIDUE);
      c.chain_start = 1'($urandom); c.beta_present = 1'($urandom);
      c.ax = 25'($urandom); c.ay = 25'($urandom); c.az = 25'($urandom);
      c.bx = 25'($urandom); c.by = 25'($urandom); c.bz = 25'($urandom);
      return c;
    end
    for (int k = 0; k < 3; k++) chain_pos[k] = wander(chain_pos[k], 3800);
    return residue($urandom_range(0, 19) == 0, chain_pos[0], chain_pos[1], chain_pos[2],
                   wander(chain_pos[0], 1600), wander(chain_pos[1], 1600),
                   wander(chain_pos[2], 1600), $urandom_range(0, 9) != 0);
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    longint mx;
    mx = (longint'(1) << 24) - 1;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // straight line gives zero u (angle 0), then two bent windows with an offset beta
    send(residue(1, 0, 0, 0, 0, 0, 0, 1));
    send(residue(0, 3800, 0, 0, 3800, 0, 1500, 1));
    send(residue(0, 7600, 0, 0, 0, 0, 0, 1));
    send(residue(0, 9000, 2000, 0, 9000, 4000, 0, 1));
    send(residue(0, 12000, 0, 0, 0, 0, 0, 1));
    // zero u and zero v
    send(residue(1, 5, 5, 5, 5, 5, 5, 1));
    send(residue(0, 5, 5, 5, 5, 5, 5, 1));
    send(residue(0, 5, 5, 5, 5, 5, 5, 0));
    // missing beta, then extremes with saturation
    send(residue(0, 100, 200, 300, 0, 0, 0, 1));
    send(residue(0, mx, -mx - 1, 9999999, -9999999, mx, -mx, 1));
    send(residue(0, -mx - 1, mx, -9999999, mx, -mx - 1, 9999999, 1));
    send(residue(0, 25'h0FFFFFF, 25'h1000000, 25'h0000001, 25'h1FFFFFF, 0, mx, 1));
    send(residue(0, mx, mx, mx, -mx, -mx, -mx, 1));
    send(plain(rsah_pkg::CMD_NOP));
    for (int b = 0; b < 4; b++) begin
      command_t c;
      c = plain(rsah_pkg::CMD_READ);
      c.read_bin = b == 0 ? 6'd0 : b == 1 ? 6'd36 : b == 2 ? 6'd37 : 6'd63;
      send(c);
    end
    send(plain(rsah_pkg::CMD_CLEAR));
    send(plain(rsah_pkg::CMD_READ));
    send(residue(0, 1, 2, 3, 4, 5, 6, 1));

    for (int n = 0; n < 2000; n++) begin
      if (n == 1000) drain();
      send(random_command());
    end
    in_valid <= 0;
    drain();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
